[rtl/ook_pulse_width_frame_transmitter_defines.svh]
// Assertion macros used by the checker file of the transmitter.
`ifndef OOK_PULSE_WIDTH_FRAME_TRANSMITTER_DEFINES_SVH
`define OOK_PULSE_WIDTH_FRAME_TRANSMITTER_DEFINES_SVH

// Concurrent assertion on an explicit clock and reset.
`define OPWT_ASSERT_ON(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Concurrent assertion on the local clk and rst.
`define OPWT_ASSERT(lbl, prop, msg) \
  `OPWT_ASSERT_ON(lbl, clk, rst, prop, msg)

`endif

[rtl/ook_pwt_pkg.sv]
// Shared types, codes and constants of the OOK pulse-width frame transmitter.
package ook_pwt_pkg;

  localparam int TICK_WIDTH    = 16;
  localparam int SYM_TICKS_W   = 16;
  localparam int PRE_CNT_W     = 6;
  localparam int HEADER_W      = 28;
  localparam int ADDR_W        = 4;
  localparam int CODE_W        = 8;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int FRAME_BITS    = HEADER_W + ADDR_W + CODE_W;
  localparam int BIT_IDX_W     = 6;
  localparam int CFG_DATA_W    = 28;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [SYM_TICKS_W-1:0] SYM_TICKS_RST = 16'd400;
  localparam logic [PRE_CNT_W-1:0]   PRE_ON_RST    = 6'd12;
  localparam logic [PRE_CNT_W-1:0]   PRE_OFF_RST   = 6'd4;
  localparam logic [HEADER_W-1:0]    HEADER_RST    = 28'h3E356EA;
  localparam logic [CODE_W-1:0]      CODE_UP_RST   = 8'h11;
  localparam logic [CODE_W-1:0]      CODE_STOP_RST = 8'h55;
  localparam logic [CODE_W-1:0]      CODE_DOWN_RST = 8'h33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOL_TICKS  = 3'd0,
    REG_PRE_ON        = 3'd1,
    REG_PRE_OFF       = 3'd2,
    REG_HEADER        = 3'd3,
    REG_CODE_UP       = 3'd4,
    REG_CODE_STOP     = 3'd5,
    REG_CODE_DOWN     = 3'd6
  } reg_index_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_UP      = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_DOWN    = 2'd2,
    CMD_INVALID = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_BAD_CMD = 2'd2
  } status_t;

  // Class of a queued beat, decided by the front end.
  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_START     = 2'd1,
    KIND_START_BAD = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SYM_TICKS_W-1:0] symbol_ticks;
    logic [PRE_CNT_W-1:0]   pre_on;
    logic [PRE_CNT_W-1:0]   pre_off;
    logic [HEADER_W-1:0]    header;
    logic [CODE_W-1:0]      code_up;
    logic [CODE_W-1:0]      code_stop;
    logic [CODE_W-1:0]      code_down;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [CODE_W-1:0] code;
  } entry_t;

  // Handshake between the queue head and the frame engine.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

[rtl/ook_pwt_if.sv]
// Channel interfaces: input beats and result beats with valid/ready.
interface ook_pwt_in_if import ook_pwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] address;
  logic [CMD_W-1:0]  command;

  modport source(output valid, operation, address, command, input ready);
  modport sink(input valid, operation, address, command, output ready);
endinterface

interface ook_pwt_out_if import ook_pwt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                carrier_on;
  logic                busy_res;
  logic                frame_done;
  logic [STATUS_W-1:0] status;

  modport source(output valid, carrier_on, busy_res, frame_done, status, input ready);
  modport sink(input valid, carrier_on, busy_res, frame_done, status, output ready);
endinterface

[rtl/ook_pulse_width_frame_transmitter.sv]
// On-off-keyed pulse-width frame transmitter. Each input beat is either a
// tick of the time base or a request to start a frame, and each one yields
// exactly one result beat in input order. The block sustains one beat per
// clock cycle in both directions when nothing stalls; a result beat passes
// through the queue and the result register before it is offered. A
// four-entry queue sits between the classifier and the keying engine, and
// together with the result register it holds five beats, so the input
// keeps taking beats while the result side is held off. The frame engine
// updates its tick, symbol and bit counters in one step per tick beat.
// Configuration registers may be written only while no beat is in flight.
module ook_pulse_width_frame_transmitter import ook_pwt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ook_pwt_in_if.sink            items,
  ook_pwt_out_if.source         results,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t  cfg;
  head_t head;
  logic  pop;

  ook_pwt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  ook_pwt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .cfg   (cfg),
    .pop   (pop),
    .head  (head)
  );

  ook_pwt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

[rtl/ook_pwt_cfg.sv]
// Configuration register file with reset values.
module ook_pwt_cfg import ook_pwt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbol_ticks <= SYM_TICKS_RST;
      cfg.pre_on       <= PRE_ON_RST;
      cfg.pre_off      <= PRE_OFF_RST;
      cfg.header       <= HEADER_RST;
      cfg.code_up      <= CODE_UP_RST;
      cfg.code_stop    <= CODE_STOP_RST;
      cfg.code_down    <= CODE_DOWN_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SYMBOL_TICKS: cfg.symbol_ticks <= wr_data[SYM_TICKS_W-1:0];
        REG_PRE_ON:       cfg.pre_on       <= wr_data[PRE_CNT_W-1:0];
        REG_PRE_OFF:      cfg.pre_off      <= wr_data[PRE_CNT_W-1:0];
        REG_HEADER:       cfg.header       <= wr_data[HEADER_W-1:0];
        REG_CODE_UP:      cfg.code_up      <= wr_data[CODE_W-1:0];
        REG_CODE_STOP:    cfg.code_stop    <= wr_data[CODE_W-1:0];
        REG_CODE_DOWN:    cfg.code_down    <= wr_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/ook_pwt_front.sv]
// Front end: classifies input beats and holds them in a short queue.
module ook_pwt_front import ook_pwt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ook_pwt_in_if.sink   items,
  input  cfg_t         cfg,
  input  logic         pop,
  output head_t        head
);

  entry_t            queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  entry_t            classified;
  logic              push;
  logic              pop_ok;

  always_comb begin
    classified.address = items.address;
    classified.code    = cfg.code_up;
    if (items.operation == OP_TICK) begin
      classified.kind = KIND_TICK;
    end else begin
      classified.kind = KIND_START;
      case (items.command)
        CMD_UP:   classified.code = cfg.code_up;
        CMD_STOP: classified.code = cfg.code_stop;
        CMD_DOWN: classified.code = cfg.code_down;
        default:  classified.kind = KIND_START_BAD;
      endcase
    end
  end

  assign items.ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push        = items.valid && items.ready;
  assign pop_ok      = pop && (count != '0);
  assign head.valid  = (count != '0);
  assign head.entry  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop_ok) begin
        count <= count + 1'b1;
      end else if (!push && pop_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ook_pwt_back.sv]
// Back end: frame keying engine and registered result beat.
module ook_pwt_back import ook_pwt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  head_t         head,
  output logic          pop,
  ook_pwt_out_if.source results
);

  localparam int CMP_W = ((TICK_WIDTH > SYM_TICKS_W) ? TICK_WIDTH : SYM_TICKS_W) + 1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRE_ON  = 2'd1,
    PH_PRE_OFF = 2'd2,
    PH_BITS    = 2'd3
  } phase_t;

  phase_t                phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [PRE_CNT_W-1:0]  symbol_count, symbol_count_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;

  logic                  carrier_next;
  logic                  done_next;
  status_t               status_next;
  logic                  sym_end;
  logic                  cur_bit;
  logic [PRE_CNT_W:0]    sym_inc;
  logic [BIT_IDX_W:0]    bit_inc;

  assign pop     = head.valid && (!results.valid || results.ready);
  assign cur_bit = frame_shift[FRAME_BITS-1];
  assign sym_inc = {1'b0, symbol_count} + 1'b1;
  assign bit_inc = {1'b0, bit_index} + 1'b1;
  // A symbol ends at the programmed length or when the counter saturates.
  assign sym_end = ((CMP_W'(tick_count) + 1'b1) >= CMP_W'(cfg.symbol_ticks)) ||
                   (tick_count == '1);

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    symbol_count_next = symbol_count;
    bit_index_next    = bit_index;
    frame_shift_next  = frame_shift;
    carrier_next      = 1'b0;
    done_next         = 1'b0;
    status_next       = ST_OK;

    case (head.entry.kind)
      KIND_START: begin
        if (phase != PH_IDLE) begin
          status_next = ST_BUSY;
        end else begin
          frame_shift_next  = {cfg.header, head.entry.address, head.entry.code};
          phase_next        = PH_PRE_ON;
          tick_count_next   = '0;
          symbol_count_next = '0;
          bit_index_next    = '0;
        end
      end
      KIND_START_BAD: begin
        status_next = (phase != PH_IDLE) ? ST_BUSY : ST_BAD_CMD;
      end
      KIND_TICK: begin
        if (phase != PH_IDLE) begin
          case (phase)
            PH_PRE_ON:  carrier_next = 1'b1;
            PH_PRE_OFF: carrier_next = 1'b0;
            default:    carrier_next = (symbol_count == '0) ||
                                       (cur_bit && symbol_count == PRE_CNT_W'(1));
          endcase

          if (!sym_end) begin
            tick_count_next = tick_count + 1'b1;
          end else begin
            tick_count_next = '0;
            case (phase)
              PH_PRE_ON: begin
                if (sym_inc >= {1'b0, cfg.pre_on}) begin
                  phase_next        = PH_PRE_OFF;
                  symbol_count_next = '0;
                end else begin
                  symbol_count_next = sym_inc[PRE_CNT_W-1:0];
                end
              end
              PH_PRE_OFF: begin
                if (sym_inc >= {1'b0, cfg.pre_off}) begin
                  phase_next        = PH_BITS;
                  symbol_count_next = '0;
                  bit_index_next    = '0;
                end else begin
                  symbol_count_next = sym_inc[PRE_CNT_W-1:0];
                end
              end
              default: begin
                // Every bit lasts three symbols; the on part depends on the bit.
                if (symbol_count >= PRE_CNT_W'(2)) begin
                  symbol_count_next = '0;
                  frame_shift_next  = {frame_shift[FRAME_BITS-2:0], 1'b0};
                  if (bit_inc >= (BIT_IDX_W + 1)'(FRAME_BITS)) begin
                    phase_next     = PH_IDLE;
                    bit_index_next = '0;
                    done_next      = 1'b1;
                  end else begin
                    bit_index_next = bit_inc[BIT_IDX_W-1:0];
                  end
                end else begin
                  symbol_count_next = sym_inc[PRE_CNT_W-1:0];
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      symbol_count  <= '0;
      bit_index     <= '0;
      frame_shift   <= '0;
      results.valid <= 1'b0;
    end else begin
      if (pop) begin
        phase              <= phase_next;
        tick_count         <= tick_count_next;
        symbol_count       <= symbol_count_next;
        bit_index          <= bit_index_next;
        frame_shift        <= frame_shift_next;
        results.valid      <= 1'b1;
        results.carrier_on <= carrier_next;
        results.busy_res   <= (phase_next != PH_IDLE);
        results.frame_done <= done_next;
        results.status     <= status_next;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/ook_pwt_checker.sv]
// Port-level checker for the transmitter, bound to the top level.
`include "ook_pulse_width_frame_transmitter_defines.svh"

module ook_pwt_checker import ook_pwt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic                carrier_on,
  input logic                busy_res,
  input logic                frame_done,
  input logic [STATUS_W-1:0] status
);

  // A result beat that is not taken stays offered.
  `OPWT_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result beat dropped")

  // The last tick of a frame is an off symbol and leaves the block idle.
  `OPWT_ASSERT(a_done_idle, res_valid && frame_done |-> !carrier_on && !busy_res, "bad frame end")

  // Rejected starts pass no tick.
  `OPWT_ASSERT(a_reject_quiet, res_valid && status != ST_OK |-> !carrier_on && !frame_done, "reject keyed")

  // Busy rejection only while a frame runs, bad command only while idle.
  `OPWT_ASSERT(a_status_busy, res_valid |-> status == ST_OK || (status == ST_BUSY && busy_res) || (status == ST_BAD_CMD && !busy_res), "status mismatch")

endmodule

bind ook_pulse_width_frame_transmitter ook_pwt_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .carrier_on (results.carrier_on),
  .busy_res   (results.busy_res),
  .frame_done (results.frame_done),
  .status     (results.status)
);

[sim/ook_pulse_width_frame_transmitter_tb.sv]
// Self-checking testbench of the OOK pulse-width frame transmitter.
module ook_pulse_width_frame_transmitter_tb;
  import ook_pwt_pkg::*;

  localparam int PHASE_COUNT = 8;
  localparam int PHASE_BEATS = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_TICKS = 50;

  typedef enum logic [1:0] {PH_IDLE, PH_PRE_ON, PH_PRE_OFF, PH_BITS} tx_phase_t;
  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  typedef struct packed {
    logic    carrier_on;
    logic    busy_res;
    logic    frame_done;
    status_t status;
  } keying_t;

  typedef struct {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    cmd_t              cmd;
    bit                typed;
    keying_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  ook_pwt_in_if  items_if();
  ook_pwt_out_if results_if();

  ook_pulse_width_frame_transmitter DUT (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .results  (results_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the transmitter: configuration and frame state.
  cfg_t                   cfg;
  tx_phase_t              tx_phase;
  logic [TICK_WIDTH-1:0]  tick_cnt;
  logic [PRE_CNT_W-1:0]   sym_cnt;
  logic [BIT_IDX_W-1:0]   bit_cnt;
  logic [FRAME_BITS-1:0]  frame_bits;

  keying_t keying_results_q[$];
  pace_t   pace = PACE_NONE;
  int      mismatches = 0;
  int      cycle_count = 0;

  dir_row_t dir_rows [7] = '{
    '{OP_TICK,  4'h0, CMD_UP,      1'b1, '{1'b0, 1'b0, 1'b0, ST_OK}},
    '{OP_START, 4'h0, CMD_INVALID, 1'b1, '{1'b0, 1'b0, 1'b0, ST_BAD_CMD}},
    '{OP_START, 4'hF, CMD_UP,      1'b1, '{1'b0, 1'b1, 1'b0, ST_OK}},
    '{OP_START, 4'h0, CMD_STOP,    1'b1, '{1'b0, 1'b1, 1'b0, ST_BUSY}},
    '{OP_START, 4'hA, CMD_INVALID, 1'b1, '{1'b0, 1'b1, 1'b0, ST_BUSY}},
    '{OP_TICK,  4'h5, CMD_DOWN,    1'b1, '{1'b1, 1'b1, 1'b0, ST_OK}},
    '{OP_TICK,  4'h3, CMD_STOP,    1'b1, '{1'b1, 1'b1, 1'b0, ST_OK}}
  };

  // Carrier level and status for one beat; advances the shadow state.
  function automatic keying_t key_one_beat(op_t op, logic [ADDR_W-1:0] addr, cmd_t cmd);
    keying_t r;
    logic [CODE_W-1:0] code;
    logic cur_bit;
    logic sym_end;
    r = '0;
    if (op == OP_START) begin
      if (tx_phase != PH_IDLE) begin
        r.status = ST_BUSY;
      end else if (cmd == CMD_INVALID) begin
        r.status = ST_BAD_CMD;
      end else begin
        case (cmd)
          CMD_UP:   code = cfg.code_up;
          CMD_STOP: code = cfg.code_stop;
          default:  code = cfg.code_down;
        endcase
        frame_bits = {cfg.header, addr, code};
        tx_phase = PH_PRE_ON;
        tick_cnt = '0;
        sym_cnt = '0;
        bit_cnt = '0;
      end
    end else if (tx_phase != PH_IDLE) begin
      cur_bit = frame_bits[FRAME_BITS-1];
      case (tx_phase)
        PH_PRE_ON:  r.carrier_on = 1'b1;
        PH_PRE_OFF: r.carrier_on = 1'b0;
        default:    r.carrier_on = (32'(sym_cnt) < (cur_bit ? 2 : 1));
      endcase
      // A zero count compares like a count of one.
      sym_end = (32'(tick_cnt) + 1 >= 32'(cfg.symbol_ticks)) || (tick_cnt == '1);
      if (!sym_end) begin
        tick_cnt = tick_cnt + 1'b1;
      end else begin
        tick_cnt = '0;
        case (tx_phase)
          PH_PRE_ON: begin
            if (32'(sym_cnt) + 1 >= 32'(cfg.pre_on)) begin
              tx_phase = PH_PRE_OFF;
              sym_cnt = '0;
            end else begin
              sym_cnt = sym_cnt + 1'b1;
            end
          end
          PH_PRE_OFF: begin
            if (32'(sym_cnt) + 1 >= 32'(cfg.pre_off)) begin
              tx_phase = PH_BITS;
              sym_cnt = '0;
              bit_cnt = '0;
            end else begin
              sym_cnt = sym_cnt + 1'b1;
            end
          end
          default: begin
            if (sym_cnt >= 2) begin
              sym_cnt = '0;
              frame_bits = frame_bits << 1;
              if (32'(bit_cnt) + 1 >= FRAME_BITS) begin
                tx_phase = PH_IDLE;
                bit_cnt = '0;
                r.frame_done = 1'b1;
              end else begin
                bit_cnt = bit_cnt + 1'b1;
              end
            end else begin
              sym_cnt = sym_cnt + 1'b1;
            end
          end
        endcase
      end
    end
    r.busy_res = (tx_phase != PH_IDLE);
    return r;
  endfunction

  function automatic bit sender_gap();
    case (pace)
      PACE_SEND: return $urandom_range(0, 99) < 58;
      PACE_BOTH: return $urandom_range(0, 99) < 15;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic send_beat(input op_t op, input logic [ADDR_W-1:0] addr, input cmd_t cmd,
                           input bit typed, input keying_t want);
    keying_t predicted;
    while (sender_gap()) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.operation <= op;
    items_if.address <= addr;
    items_if.command <= cmd;
    do @(posedge clk); while (!items_if.ready);
    predicted = key_one_beat(op, addr, cmd);
    keying_results_q.push_back(typed ? want : predicted);
  endtask

  // Address and command are ignored on a tick, so they carry noise.
  task automatic send_tick();
    send_beat(OP_TICK, 4'($urandom), cmd_t'($urandom_range(0, 3)), 1'b0, '0);
  endtask

  task automatic hold_until_drained();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (keying_results_q.size() != 0);
  endtask

  // Writes every register, plus the unused index; narrow registers get junk upper bits.
  task automatic load_config(input cfg_t c);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      idx = i[CFG_IDX_W-1:0];
      data = CFG_DATA_W'($urandom);
      case (idx)
        REG_SYMBOL_TICKS: data[SYM_TICKS_W-1:0] = c.symbol_ticks;
        REG_PRE_ON:       data[PRE_CNT_W-1:0] = c.pre_on;
        REG_PRE_OFF:      data[PRE_CNT_W-1:0] = c.pre_off;
        REG_HEADER:       data[HEADER_W-1:0] = c.header;
        REG_CODE_UP:      data[CODE_W-1:0] = c.code_up;
        REG_CODE_STOP:    data[CODE_W-1:0] = c.code_stop;
        REG_CODE_DOWN:    data[CODE_W-1:0] = c.code_down;
        default:          ;
      endcase
      wr_en <= 1'b1;
      wr_index <= idx;
      wr_data <= data;
      @(posedge clk);
    end
    wr_en <= 1'b0;
    cfg = c;
  endtask

  always @(posedge clk) begin : result_check
    keying_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (keying_results_q.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want = keying_results_q.pop_front();
        if (results_if.carrier_on !== want.carrier_on) begin
          $error("carrier_on: expected %0d, got %0d", want.carrier_on, results_if.carrier_on);
          mismatches++;
        end
        if (results_if.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, results_if.busy_res);
          mismatches++;
        end
        if (results_if.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, results_if.frame_done);
          mismatches++;
        end
        if (results_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, results_if.status);
          mismatches++;
        end
      end
    end
    case (pace)
      PACE_RECV: results_if.ready <= $urandom_range(0, 99) >= 58;
      PACE_BOTH: results_if.ready <= $urandom_range(0, 99) >= 15;
      default:   results_if.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ook_pulse_width_frame_transmitter_tb: done, errors");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    cmd_t cmd;
    bit start;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    items_if.valid <= 1'b0;
    items_if.operation <= OP_TICK;
    items_if.address <= '0;
    items_if.command <= CMD_UP;
    cfg = '{SYM_TICKS_RST, PRE_ON_RST, PRE_OFF_RST, HEADER_RST,
            CODE_UP_RST, CODE_STOP_RST, CODE_DOWN_RST};
    tx_phase = PH_IDLE;
    tick_cnt = '0;
    sym_cnt = '0;
    bit_cnt = '0;
    frame_bits = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset configuration; the frame it starts runs on
    // into the random phases, which key it out at their shorter symbols.
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].cmd,
                dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       c = '{16'd1, 6'd1, 6'd1, 28'h0, 8'h00, 8'h00, 8'h00};
        1:       c = '{16'd0, 6'd0, 6'd0, 28'hFFFFFFF, 8'hFF, 8'hFF, 8'hFF};
        2:       c = '{16'd2, 6'd63, 6'd63, 28'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom)};
        default: c = '{16'($urandom_range(1, 3)), 6'($urandom_range(0, 9)),
                       6'($urandom_range(0, 9)), 28'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      load_config(c);
      pace = pace_t'(p % 4);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ((p == 1 && n == PHASE_BEATS / 2) || $urandom_range(0, 299) == 0)
          hold_until_drained();
        // Mostly whole frames; starts during a frame are the rejected kind.
        if (tx_phase == PH_IDLE)
          start = $urandom_range(0, 1);
        else
          start = ($urandom_range(0, 31) == 0);
        if (start) begin
          cmd = ($urandom_range(0, 7) == 0) ? CMD_INVALID : cmd_t'($urandom_range(0, 2));
          send_beat(OP_START, 4'($urandom), cmd, 1'b0, '0);
        end else begin
          send_tick();
        end
      end
    end

    // Longest symbol: no symbol boundary may come early.
    pace = PACE_NONE;
    load_config('{16'hFFFF, 6'd1, 6'd1, 28'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom)});
    send_beat(OP_START, 4'($urandom), CMD_UP, 1'b0, '0);
    for (int n = 0; n < LONG_TICKS; n++) send_tick();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ook_pulse_width_frame_transmitter_tb: done, clean");
    else
      $display("ook_pulse_width_frame_transmitter_tb: done, errors");
    $finish;
  end

endmodule
